// File: design/pcvo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcvo_pkg
// Shared types, constants and helpers for the polygon convexity and
// orientation block.
// ----------------------------------------------------------------------------
package pcvo_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int COORD_W      = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

	typedef logic [CNT_W-1:0] cnt_t;

	// one vertex as it arrives
	typedef struct packed {
		logic signed [COORD_W-1:0] vx;
		logic signed [COORD_W-1:0] vy;
		logic                      last_vertex;
	} in_item_t;

	// one polygon summary
	typedef struct packed {
		logic             convex;
		logic             ccw;
		logic [12:0]      positive_turns;
		logic [12:0]      vertex_count;
		logic             overflow;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	// three triples for one vertex: sliding (older, newer, cur),
	// wrap (newer, cur, first) and wrap (cur, first, second)
	typedef struct packed {
		point_t older;
		point_t newer;
		point_t cur;
		point_t first;
		point_t second;
		logic   slide_en;
		logic   wrap_en;
		logic   last;
		cnt_t   total;
		logic   ovf;
	} tri_job_t;

	// per-vertex bookkeeping that rides along the pipeline
	typedef struct packed {
		logic slide_en;
		logic wrap_en;
		logic last;
		cnt_t total;
		logic ovf;
	} job_meta_t;

	// two products of one cross product
	typedef struct packed {
		logic signed [PROD_W-1:0] p0;
		logic signed [PROD_W-1:0] p1;
	} cross_prod_t;

	// signs of the three triples, ready for counting
	typedef struct packed {
		logic [2:0] pos;
		logic       last;
		cnt_t       total;
		logic       ovf;
	} turn_t;

	// (a - b) x (c - b) split into its two products
	function automatic cross_prod_t cross_products(point_t a, point_t b, point_t c);
		logic signed [DIFF_W-1:0] dx0;
		logic signed [DIFF_W-1:0] dy0;
		logic signed [DIFF_W-1:0] dx1;
		logic signed [DIFF_W-1:0] dy1;
		cross_prod_t r;
		dx0  = DIFF_W'(a.x) - DIFF_W'(b.x);
		dy0  = DIFF_W'(a.y) - DIFF_W'(b.y);
		dx1  = DIFF_W'(c.x) - DIFF_W'(b.x);
		dy1  = DIFF_W'(c.y) - DIFF_W'(b.y);
		r.p0 = dx0 * dy1;
		r.p1 = dy0 * dx1;
		return r;
	endfunction

endpackage : pcvo_pkg
`default_nettype wire

// File: design/polygon_convexity_orientation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one vertex per cycle while vertex_stall is low, through three
// register stages (vertex window, cross product multipliers, sign compare)
// and the result register. vertex_stall rises only while a finished summary
// waits in stage three behind a stalled result. arst_n clears all counts and
// valid bits at once.
// ----------------------------------------------------------------------------
// polygon_convexity_orientation_top
// Streaming polygon convexity and orientation test over cyclic cross
// products of consecutive vertices.
// ----------------------------------------------------------------------------
module polygon_convexity_orientation_top
	import pcvo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t vertex,
	input  wire logic     vertex_valid,
	output logic          vertex_stall,
	output out_item_t     result,
	output logic          result_valid,
	input  wire logic     result_stall
);

	logic     en;
	tri_job_t job_s1;
	logic     valid_s1;
	turn_t    turn_s3;
	logic     valid_s3;

	assign vertex_stall = !en;

	pcvo_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.vertex_valid (vertex_valid),
		.vertex       (vertex),
		.job_s1       (job_s1),
		.valid_s1     (valid_s1)
	);

	pcvo_turns u_turns (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.job_s1   (job_s1),
		.valid_s1 (valid_s1),
		.turn_s3  (turn_s3),
		.valid_s3 (valid_s3)
	);

	pcvo_tally u_tally (
		.clk          (clk),
		.arst_n       (arst_n),
		.turn_s3      (turn_s3),
		.valid_s3     (valid_s3),
		.result_stall (result_stall),
		.result       (result),
		.result_valid (result_valid),
		.en           (en)
	);

	// stall only comes from a summary blocked behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_stall |-> (result_valid && result_stall && valid_s3 && turn_s3.last))
		else $error("vertex stall without a blocked result");

	// positive turns never exceed the vertex count
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.positive_turns <= result.vertex_count))
		else $error("positive turns above vertex count");

	// a summary always covers at least one vertex
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.vertex_count != 13'd0))
		else $error("empty polygon summary");

	// overflow only with a saturated vertex count
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.overflow) |-> (result.vertex_count == CNT_MAX[12:0]))
		else $error("overflow without saturated count");

endmodule : polygon_convexity_orientation_top
`default_nettype wire

// File: design/pcvo_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcvo_window
// Holds the first two and the two most recent vertices and the vertex count,
// and registers the triples of each accepted vertex into stage one.
// ----------------------------------------------------------------------------
module pcvo_window
	import pcvo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     vertex_valid,
	input  wire in_item_t vertex,
	output tri_job_t      job_s1,
	output logic          valid_s1
);

	point_t first_q;
	point_t second_q;
	point_t older_q;
	point_t newer_q;
	cnt_t   count_seen_q;
	logic   overflowed_q;

	logic     accept;
	point_t   cur;
	cnt_t     cnt_next;
	logic     ovf_next;
	tri_job_t job;

	assign accept = vertex_valid && en;
	assign cur    = '{x: vertex.vx, y: vertex.vy};

	// saturating vertex count
	always_comb begin
		if (count_seen_q < CNT_MAX) begin
			cnt_next = count_seen_q + cnt_t'(1);
			ovf_next = overflowed_q;
		end else begin
			cnt_next = count_seen_q;
			ovf_next = 1'b1;
		end
	end

	// triples of this vertex
	always_comb begin
		job.older    = older_q;
		job.newer    = newer_q;
		job.cur      = cur;
		job.first    = first_q;
		job.second   = second_q;
		job.slide_en = (count_seen_q >= cnt_t'(2));
		job.wrap_en  = vertex.last_vertex && (cnt_next >= cnt_t'(3));
		job.last     = vertex.last_vertex;
		job.total    = cnt_next;
		job.ovf      = ovf_next;
	end

	// per-polygon control state, cleared after the last vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_seen_q <= '0;
			overflowed_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
			if (accept) begin
				if (vertex.last_vertex) begin
					count_seen_q <= '0;
					overflowed_q <= 1'b0;
				end else begin
					count_seen_q <= cnt_next;
					overflowed_q <= ovf_next;
				end
			end
		end
	end

	// vertex storage and stage one payload
	always_ff @(posedge clk) begin
		if (en) begin
			job_s1 <= job;
		end
		if (accept) begin
			if (count_seen_q == cnt_t'(0)) begin
				first_q <= cur;
			end
			if (count_seen_q == cnt_t'(1)) begin
				second_q <= cur;
			end
			if (!vertex.last_vertex) begin
				older_q <= newer_q;
				newer_q <= cur;
			end
		end
	end

endmodule : pcvo_window
`default_nettype wire

// File: design/pcvo_turns.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcvo_turns
// Cross products of the three triples: products registered in stage two,
// strict sign compare registered in stage three.
// ----------------------------------------------------------------------------
module pcvo_turns
	import pcvo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire tri_job_t job_s1,
	input  wire logic     valid_s1,
	output turn_t         turn_s3,
	output logic          valid_s3
);

	cross_prod_t slide_s2;
	cross_prod_t wrap0_s2;
	cross_prod_t wrap1_s2;
	job_meta_t   meta_s2;
	logic        valid_s2;

	job_meta_t meta_s1;
	turn_t     turn;

	assign meta_s1 = '{slide_en: job_s1.slide_en, wrap_en: job_s1.wrap_en,
		last: job_s1.last, total: job_s1.total, ovf: job_s1.ovf};

	// z > 0 is p0 > p1, masked by which triples exist
	always_comb begin
		turn.pos[0] = meta_s2.slide_en && (slide_s2.p0 > slide_s2.p1);
		turn.pos[1] = meta_s2.wrap_en && (wrap0_s2.p0 > wrap0_s2.p1);
		turn.pos[2] = meta_s2.wrap_en && (wrap1_s2.p0 > wrap1_s2.p1);
		turn.last   = meta_s2.last;
		turn.total  = meta_s2.total;
		turn.ovf    = meta_s2.ovf;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// product and sign registers
	always_ff @(posedge clk) begin
		if (en) begin
			slide_s2 <= cross_products(job_s1.older, job_s1.newer, job_s1.cur);
			wrap0_s2 <= cross_products(job_s1.newer, job_s1.cur, job_s1.first);
			wrap1_s2 <= cross_products(job_s1.cur, job_s1.first, job_s1.second);
			meta_s2  <= meta_s1;
			turn_s3  <= turn;
		end
	end

endmodule : pcvo_turns
`default_nettype wire

// File: design/pcvo_tally.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcvo_tally
// Saturating count of positive turns and the result register; a polygon
// summary is formed as its last vertex leaves stage three.
// ----------------------------------------------------------------------------
module pcvo_tally
	import pcvo_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire turn_t turn_s3,
	input  wire logic  valid_s3,
	input  wire logic  result_stall,
	output out_item_t  result,
	output logic       result_valid,
	output logic       en
);

	cnt_t count_positive_q;

	logic            res_free;
	logic            retire;
	logic [1:0]      inc;
	logic [CNT_W:0]  sum;
	cnt_t            pos;
	out_item_t       res;

	// only a finished polygon waits on the result register
	assign res_free = !result_valid || !result_stall;
	assign en       = !(valid_s3 && turn_s3.last && !res_free);
	assign retire   = valid_s3 && en;

	// add up to three turns, saturating
	always_comb begin
		inc = 2'(turn_s3.pos[0]) + 2'(turn_s3.pos[1]) + 2'(turn_s3.pos[2]);
		sum = {1'b0, count_positive_q} + (CNT_W + 1)'(inc);
		pos = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
	end

	// polygon summary
	always_comb begin
		res.convex         = (pos == cnt_t'(0)) || (pos == turn_s3.total);
		res.ccw            = ({pos, 1'b0} < {1'b0, turn_s3.total});
		res.positive_turns = pos[12:0];
		res.vertex_count   = turn_s3.total[12:0];
		res.overflow       = turn_s3.ovf;
	end

	// count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_positive_q <= '0;
			result_valid     <= 1'b0;
		end else begin
			if (retire) begin
				count_positive_q <= turn_s3.last ? '0 : pos;
			end
			if (retire && turn_s3.last) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (retire && turn_s3.last) begin
			result <= res;
		end
	end

endmodule : pcvo_tally
`default_nettype wire

// File: sim/polygon_convexity_orientation_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_convexity_orientation_top_test
// Streams polygons into the convexity and orientation block: first a few
// hand-made shapes, some at the coordinate extremes, then random convex and
// scattered polygons of one vertex up to 64.
// Every accepted vertex drives an in-bench tally of turns, and each polygon
// summary that comes out is compared field by field with that tally. Both
// sides idle at random, and the result side also holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module polygon_convexity_orientation_top_test;
	import pcvo_pkg::*;

	localparam int IDLE_LIMIT       = 4000;
	localparam int LONG_HOLD_CYCLES = 250;
	localparam int LONG_HOLD_AT     = 300;
	localparam int QUIET_TAIL       = 150;
	localparam int RANDOM_GOAL      = 1000;

	typedef struct {
		in_item_t v;
		bit       wait_drain;
	} pending_vertex_t;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	in_item_t  vertex       = '0;
	logic      vertex_valid = 1'b0;
	logic      vertex_stall;
	out_item_t result;
	logic      result_valid;
	logic      result_stall = 1'b0;

	// vertices still to be offered, polygon summaries still to come out
	pending_vertex_t vertex_q[$];
	out_item_t       summary_q[$];

	// running tally of the polygon being received
	point_t poly_first;
	point_t poly_second;
	point_t win_older;
	point_t win_newer;
	int     seen_cnt  = 0;
	int     pos_cnt   = 0;
	bit     over_seen = 1'b0;

	// octagon directions in order of increasing angle
	int oct_dx[8] = '{4, 3, 0, -3, -4, -3, 0, 3};
	int oct_dy[8] = '{0, 3, 4, 3, 0, -3, -4, -3};

	int   total_vertices   = 0;
	int   vertices_in      = 0;
	int   polygons_checked = 0;
	int   convex_seen      = 0;
	int   overflow_seen    = 0;
	int   failures         = 0;
	int   idle_cycles      = 0;
	int   cycle_cnt        = 0;
	int   tx_idle_pct      = 10;
	int   rx_idle_pct      = 10;
	int   tx_gap_left      = 0;
	int   rx_gap_left      = 0;
	int   rx_hold_left     = 0;
	bit   hold_done        = 1'b0;
	logic long_hold_on     = 1'b0;
	bit   vertex_taken     = 1'b0;
	logic quiet;

	assign quiet = (vertices_in + QUIET_TAIL >= total_vertices);

	polygon_convexity_orientation_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.vertex      (vertex),
		.vertex_valid(vertex_valid),
		.vertex_stall(vertex_stall),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	always #1 clk = ~clk;

	// count one triple if it turns strictly positive, saturating
	task automatic tally_turn(point_t a, point_t b, point_t c);
		longint dx0;
		longint dy0;
		longint dx1;
		longint dy1;
		dx0 = longint'(a.x) - longint'(b.x);
		dy0 = longint'(a.y) - longint'(b.y);
		dx1 = longint'(c.x) - longint'(b.x);
		dy1 = longint'(c.y) - longint'(b.y);
		if (dx0 * dy1 - dy0 * dx1 > 0 && pos_cnt < MAX_VERTICES)
			pos_cnt++;
	endtask

	// advance the tally by one vertex; a last vertex closes the polygon
	task automatic tally_vertex(in_item_t v);
		point_t    p;
		out_item_t s;
		p.x = v.vx;
		p.y = v.vy;
		if (seen_cnt == 0)
			poly_first = p;
		else if (seen_cnt == 1)
			poly_second = p;
		else
			tally_turn(win_older, win_newer, p);
		if (seen_cnt < MAX_VERTICES)
			seen_cnt++;
		else
			over_seen = 1'b1;
		if (!v.last_vertex) begin
			win_older = win_newer;
			win_newer = p;
		end else begin
			// the two triples that wrap around to the first vertices
			if (seen_cnt >= 3) begin
				tally_turn(win_newer, p, poly_first);
				tally_turn(p, poly_first, poly_second);
			end
			s.convex         = (pos_cnt == 0 || pos_cnt == seen_cnt);
			s.ccw            = (2 * pos_cnt < seen_cnt);
			s.positive_turns = 13'(pos_cnt);
			s.vertex_count   = 13'(seen_cnt);
			s.overflow       = over_seen;
			summary_q.push_back(s);
			poly_first  = '0;
			poly_second = '0;
			win_older   = '0;
			win_newer   = '0;
			seen_cnt    = 0;
			pos_cnt     = 0;
			over_seen   = 1'b0;
		end
	endtask

	task automatic add_vertex(int x, int y, bit last, bit drain);
		pending_vertex_t e;
		e.v.vx          = 16'(x);
		e.v.vy          = 16'(y);
		e.v.last_vertex = last;
		e.wait_drain    = drain;
		vertex_q.push_back(e);
	endtask

	// full range with the extremes and zero favored
	function automatic int any_coord();
		case ($urandom_range(0, 7))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// random points, either anywhere or clustered so that repeats and
	// collinear triples come up often
	task automatic add_scatter_polygon(int n, bit near, bit drain);
		int base_x;
		int base_y;
		int k;
		base_x = int'($urandom_range(0, 32000)) - 16000;
		base_y = int'($urandom_range(0, 32000)) - 16000;
		for (k = 0; k < n; k++) begin
			if (near)
				add_vertex(base_x + int'($urandom_range(0, 8)) - 4,
					base_y + int'($urandom_range(0, 8)) - 4, k == n - 1, drain && k == 0);
			else
				add_vertex(any_coord(), any_coord(), k == n - 1, drain && k == 0);
		end
	endtask

	// subset of a scaled octagon, walked either way round
	task automatic add_convex_polygon(bit drain);
		int mask;
		int n;
		int r;
		int lim;
		int cx;
		int cy;
		int start;
		int k;
		int idx;
		int sent;
		bit backward;
		do
			mask = int'($urandom_range(1, 255));
		while ($countones(mask) < 3);
		n        = $countones(mask);
		r        = int'($urandom_range(1, 8000));
		lim      = 32767 - 4 * r;
		cx       = int'($urandom_range(0, 2 * lim)) - lim;
		cy       = int'($urandom_range(0, 2 * lim)) - lim;
		backward = 1'($urandom_range(0, 1));
		start    = int'($urandom_range(0, 7));
		sent     = 0;
		for (k = 0; k < 8; k++) begin
			idx = backward ? ((start - k) & 7) : ((start + k) & 7);
			if (mask[idx]) begin
				add_vertex(cx + r * oct_dx[idx], cy + r * oct_dy[idx], sent == n - 1,
					drain && sent == 0);
				sent++;
			end
		end
	endtask

	task automatic add_random_polygons(int goal);
		int before_cnt;
		int kind;
		int n;
		bit drain;
		before_cnt = vertex_q.size();
		while (vertex_q.size() - before_cnt < goal) begin
			drain = ($urandom_range(0, 99) < 3);
			kind  = int'($urandom_range(0, 99));
			if (kind < 40) begin
				add_convex_polygon(drain);
			end else begin
				if (kind < 50)
					n = int'($urandom_range(1, 2));
				else if (kind < 55)
					n = int'($urandom_range(13, 64));
				else
					n = int'($urandom_range(3, 12));
				add_scatter_polygon(n, kind >= 85, drain);
			end
		end
	endtask

	// stimulus, reset and end of run
	initial begin
		// single vertex at a corner of the range, then two vertices, one at a corner
		add_vertex(-32768, 32767, 1'b1, 1'b0);
		add_vertex(32767, -32768, 1'b0, 1'b0);
		add_vertex(0, 0, 1'b1, 1'b0);
		// a triangle both ways round, then three collinear points
		add_vertex(0, 0, 1'b0, 1'b0);
		add_vertex(100, 0, 1'b0, 1'b0);
		add_vertex(0, 100, 1'b1, 1'b0);
		add_vertex(0, 0, 1'b0, 1'b0);
		add_vertex(0, 100, 1'b0, 1'b0);
		add_vertex(100, 0, 1'b1, 1'b0);
		add_vertex(0, 0, 1'b0, 1'b1);
		add_vertex(5, 5, 1'b0, 1'b0);
		add_vertex(10, 10, 1'b1, 1'b0);
		// full-range square, largest products
		add_vertex(-32768, -32768, 1'b0, 1'b0);
		add_vertex(32767, -32768, 1'b0, 1'b0);
		add_vertex(32767, 32767, 1'b0, 1'b0);
		add_vertex(-32768, 32767, 1'b1, 1'b0);
		// concave quad
		add_vertex(0, 0, 1'b0, 1'b0);
		add_vertex(10, 0, 1'b0, 1'b0);
		add_vertex(3, 3, 1'b0, 1'b0);
		add_vertex(0, 10, 1'b1, 1'b0);
		// one point three times over
		add_vertex(7, 7, 1'b0, 1'b0);
		add_vertex(7, 7, 1'b0, 1'b0);
		add_vertex(7, 7, 1'b1, 1'b0);

		add_random_polygons(RANDOM_GOAL);
		add_random_polygons(RANDOM_GOAL);
		total_vertices = vertex_q.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (vertices_in < total_vertices)
			@(posedge clk);
		while (summary_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d vertices sent, %0d polygon summaries checked", vertices_in,
			polygons_checked);
		$display("%0d summaries convex, %0d with vertex overflow, %0d failures",
			convex_seen, overflow_seen, failures);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// vertex side: predict on each transfer
	always @(posedge clk) begin
		vertex_taken = arst_n && vertex_valid && !vertex_stall;
		if (vertex_taken) begin
			tally_vertex(vertex);
			vertices_in++;
		end
	end

	// vertex side: offer the next vertex, hold while stalled, idle in bursts
	always @(negedge clk) begin
		pending_vertex_t nxt;
		logic            next_valid;
		in_item_t        next_vertex;
		next_valid  = 1'b0;
		next_vertex = vertex;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (vertex_valid && !vertex_taken) begin
			next_valid = 1'b1;
		end else if (tx_gap_left != 0) begin
			tx_gap_left--;
		end else if (vertex_q.size() != 0
				&& !(vertex_q[0].wait_drain && summary_q.size() != 0)) begin
			if (!quiet && !long_hold_on && $urandom_range(0, 99) < tx_idle_pct) begin
				tx_gap_left = int'($urandom_range(1, 19)) - 1;
			end else begin
				nxt         = vertex_q.pop_front();
				next_vertex = nxt.v;
				next_valid  = 1'b1;
			end
		end
		vertex_valid <= next_valid;
		vertex       <= next_vertex;
	end

	// result side: one long hold-off, otherwise stall bursts
	always @(negedge clk) begin
		logic next_stall;
		next_stall = 1'b0;
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			next_stall = 1'b1;
		end else if (!hold_done && vertices_in >= LONG_HOLD_AT) begin
			hold_done    = 1'b1;
			rx_hold_left = LONG_HOLD_CYCLES - 1;
			next_stall   = 1'b1;
		end else if (rx_gap_left != 0) begin
			rx_gap_left--;
			next_stall = 1'b1;
		end else if (arst_n && !quiet && $urandom_range(0, 99) < rx_idle_pct) begin
			rx_gap_left = int'($urandom_range(1, 19)) - 1;
			next_stall  = 1'b1;
		end
		result_stall <= next_stall;
		long_hold_on <= (rx_hold_left != 0);
	end

	// result side: compare each summary with the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (summary_q.size() == 0) begin
				failures++;
				$error("summary with none expected: %h", result);
			end else begin
				want = summary_q.pop_front();
				polygons_checked++;
				if (result.convex)
					convex_seen++;
				if (result.overflow)
					overflow_seen++;
				if (result.convex !== want.convex) begin
					failures++;
					$error("convex: expected %0d, actual %0d", want.convex, result.convex);
				end
				if (result.ccw !== want.ccw) begin
					failures++;
					$error("ccw: expected %0d, actual %0d", want.ccw, result.ccw);
				end
				if (result.positive_turns !== want.positive_turns) begin
					failures++;
					$error("positive_turns: expected %0d, actual %0d",
						want.positive_turns, result.positive_turns);
				end
				if (result.vertex_count !== want.vertex_count) begin
					failures++;
					$error("vertex_count: expected %0d, actual %0d",
						want.vertex_count, result.vertex_count);
				end
				if (result.overflow !== want.overflow) begin
					failures++;
					$error("overflow: expected %0d, actual %0d", want.overflow,
						result.overflow);
				end
			end
		end
	end

	// watchdog on cycles with no transfer; idle rates change now and then
	always @(posedge clk) begin
		if (!arst_n || (vertex_valid && !vertex_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
		cycle_cnt++;
		if (cycle_cnt % 256 == 0) begin
			case ($urandom_range(0, 2))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 8;
				default: tx_idle_pct = 30;
			endcase
			case ($urandom_range(0, 2))
				0: rx_idle_pct = 0;
				1: rx_idle_pct = 8;
				default: rx_idle_pct = 30;
			endcase
		end
	end

endmodule
